// ===== rtl/core/mouse_look_vector_rotator_top_defines.svh =====
// Assertion macros used by the rotator top level.
// Each one assumes clock aclk and active low reset aresetn in scope.
`ifndef MOUSE_LOOK_VECTOR_ROTATOR_TOP_DEFINES_SVH
`define MOUSE_LOOK_VECTOR_ROTATOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MLVR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MLVR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mlvr_pkg.sv =====
package mlvr_pkg;

    // default parameter values
    localparam int COORD_BITS_DEF     = 13;
    localparam int ROTATION_STEPS_DEF = 16;

    // field widths
    localparam int VEC_BITS    = 16;
    localparam int SENS_BITS   = 16;
    localparam int WIN_BITS    = 13;
    localparam int CENTER_BITS = 12;
    localparam int ACT_BITS    = 2;
    localparam int NUM_VECS    = 4;
    localparam int M_DATA_BITS = 96;

    // config port
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ENABLE      = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SENSITIVITY = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WIN_WIDTH   = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_WIN_HEIGHT  = 2'd3;

    localparam logic                 ENABLE_RST = 1'b1;
    localparam logic [SENS_BITS-1:0] SENS_RST   = 16'd197;
    localparam logic [WIN_BITS-1:0]  WIN_W_RST  = 13'd1280;
    localparam logic [WIN_BITS-1:0]  WIN_H_RST  = 13'd720;

    // cursor actions
    localparam logic [ACT_BITS-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_SHOW = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_WARP = 2'd2;

    localparam int RECENTER_LIMIT = 50;

    // angle arithmetic: Q16 product, Q32 for reduction, Q30 for CORDIC
    localparam int FRAC_WIDEN = 16;
    localparam int TP_BITS    = 35;   // width of 2*pi in Q32
    localparam int TP_LOG2    = 34;   // 2^34 <= 2*pi in Q32
    localparam logic [TP_BITS-1:0] TWO_PI_Q32 = 35'd26986075409;
    localparam logic [TP_BITS-1:0] PI_Q32     = 35'd13493037704;

    localparam int Z_BITS = 34;
    localparam logic signed [Z_BITS-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_BITS-1:0] PI_Q30      = 34'sd3373259426;

    // vector datapath: Q2.14 plus 8 guard bits, headroom for CORDIC growth
    localparam int GUARD_BITS = 8;
    localparam int W_BITS     = 27;
    localparam int GAIN_BITS  = 31;
    localparam logic signed [GAIN_BITS-1:0] GAIN_INV_Q30 = 31'sd652032874;
    localparam int OUT_SHIFT  = 38;

    localparam int ATAN_IDX_BITS = 5;

    typedef struct packed {
        logic start;
        logic negative;
    } angle_req_t;

    function automatic logic signed [Z_BITS-1:0] atan_q30(
        input logic [ATAN_IDX_BITS-1:0] idx
    );
        logic signed [Z_BITS-1:0] v;
        case (idx)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043837;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048576;
            5'd11:   v = 34'sd524288;
            5'd12:   v = 34'sd262144;
            5'd13:   v = 34'sd131072;
            5'd14:   v = 34'sd65536;
            5'd15:   v = 34'sd32768;
            5'd16:   v = 34'sd16384;
            5'd17:   v = 34'sd8192;
            5'd18:   v = 34'sd4096;
            5'd19:   v = 34'sd2048;
            5'd20:   v = 34'sd1024;
            5'd21:   v = 34'sd512;
            5'd22:   v = 34'sd256;
            5'd23:   v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/mlvr_angle.sv =====
// Angle unit: radix-4 serial multiply of |delta| by sensitivity, then
// restoring reduction modulo 2*pi one quotient bit a cycle, then wrap
// into (-pi, pi] and round to Q30.
module mlvr_angle #(
    parameter int COORD_BITS = mlvr_pkg::COORD_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mlvr_pkg::angle_req_t                  req,
    input  logic [COORD_BITS-1:0]                 delta_mag,
    input  logic [mlvr_pkg::SENS_BITS-1:0]        sensitivity,
    output logic                                  done,
    output logic signed [mlvr_pkg::Z_BITS-1:0]    angle
);

    localparam int PROD_BITS = COORD_BITS + mlvr_pkg::SENS_BITS;
    localparam int MAG_BITS  = PROD_BITS + mlvr_pkg::FRAC_WIDEN;
    localparam int QUO_BITS  = MAG_BITS - mlvr_pkg::TP_LOG2;
    localparam int MUL_STEPS = mlvr_pkg::SENS_BITS / 2;
    localparam int CNT_MAX   = (QUO_BITS > MUL_STEPS) ? QUO_BITS : MUL_STEPS;
    localparam int CNT_BITS  = $clog2(CNT_MAX);
    localparam int TPB       = mlvr_pkg::TP_BITS;
    localparam int ZB        = mlvr_pkg::Z_BITS;

    localparam logic [2:0] AS_IDLE  = 3'd0;
    localparam logic [2:0] AS_MUL   = 3'd1;
    localparam logic [2:0] AS_MOD   = 3'd2;
    localparam logic [2:0] AS_WRAP  = 3'd3;
    localparam logic [2:0] AS_ANGLE = 3'd4;

    localparam logic [MAG_BITS-1:0] DVS_INIT =
        MAG_BITS'(mlvr_pkg::TWO_PI_Q32) << (QUO_BITS - 1);

    logic [2:0]                       state_reg;
    logic [CNT_BITS-1:0]              cnt_reg;
    logic [PROD_BITS-1:0]             mcand_reg;
    logic [PROD_BITS-1:0]             mcand3_reg;
    logic [mlvr_pkg::SENS_BITS-1:0]   mplier_reg;
    logic [PROD_BITS-1:0]             acc_reg;
    logic [PROD_BITS-1:0]             acc_next;
    logic [PROD_BITS-1:0]             addend;
    logic [MAG_BITS-1:0]              rem_reg;
    logic [MAG_BITS-1:0]              dvs_reg;
    logic                             neg_reg;
    logic [TPB-1:0]                   r1_reg;
    logic [TPB-1:0]                   rem_low;
    logic signed [TPB+1:0]            sum;
    logic                             done_reg;
    logic signed [ZB-1:0]             angle_reg;

    always_comb begin
        case (mplier_reg[1:0])
            2'd0:    addend = '0;
            2'd1:    addend = mcand_reg;
            2'd2:    addend = mcand_reg << 1;
            default: addend = mcand3_reg;
        endcase
        acc_next = acc_reg + addend;
        rem_low  = rem_reg[TPB-1:0];
        sum = $signed({2'b00, r1_reg}) + (TPB+2)'(2)
            - ((r1_reg > mlvr_pkg::PI_Q32) ? $signed({2'b00, mlvr_pkg::TWO_PI_Q32})
                                           : (TPB+2)'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                AS_IDLE: begin
                    if (req.start) begin
                        state_reg <= AS_MUL;
                        cnt_reg   <= '0;
                    end
                end
                AS_MUL: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(MUL_STEPS - 1)) begin
                        cnt_reg   <= '0;
                        state_reg <= AS_MOD;
                    end
                end
                AS_MOD: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_BITS'(QUO_BITS - 1)) begin
                        state_reg <= AS_WRAP;
                    end
                end
                AS_WRAP: begin
                    state_reg <= AS_ANGLE;
                end
                AS_ANGLE: begin
                    done_reg  <= 1'b1;
                    state_reg <= AS_IDLE;
                end
                default: state_reg <= AS_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        case (state_reg)
            AS_IDLE: begin
                if (req.start) begin
                    mcand_reg  <= PROD_BITS'(delta_mag);
                    mcand3_reg <= PROD_BITS'(delta_mag) + (PROD_BITS'(delta_mag) << 1);
                    mplier_reg <= sensitivity;
                    acc_reg    <= '0;
                    neg_reg    <= req.negative;
                end
            end
            AS_MUL: begin
                acc_reg    <= acc_next;
                mcand_reg  <= mcand_reg << 2;
                mcand3_reg <= mcand3_reg << 2;
                mplier_reg <= mplier_reg >> 2;
                rem_reg    <= {acc_next, {mlvr_pkg::FRAC_WIDEN{1'b0}}};
                dvs_reg    <= DVS_INIT;
            end
            AS_MOD: begin
                if (rem_reg >= dvs_reg) begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                dvs_reg <= dvs_reg >> 1;
            end
            AS_WRAP: begin
                // negative product: mirror the remainder
                r1_reg <= (neg_reg && (rem_low != '0)) ? mlvr_pkg::TWO_PI_Q32 - rem_low
                                                       : rem_low;
            end
            AS_ANGLE: begin
                angle_reg <= sum[ZB+1:2];
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

// ===== rtl/core/mouse_look_vector_rotator_top.sv =====
// Channel  Dir  Payload                                         Handshake
// s_       in   pointer_x/y, view_dir_x/y, view_plane_x/y       s_tvalid/s_tready
// m_       out  rotated_dir_x/y, rotated_plane_x/y, cursor      m_tvalid/m_tready
//               action, warp_x/y
// cfg_     in   enable, sensitivity, window width/height        cfg_wr_en, no wait
//
// One item at a time. An item that needs no rotation goes straight to the output stage.
// A rotated item runs through the angle unit, the fold, CORDIC and gain stages:
// 8 radix-4 multiply steps and COORD_BITS-2 reduction steps in the angle unit,
// then one CORDIC iteration per cycle and each vector through the shared multiplier.
// Reset (aresetn low, synchronous) sets control, state and config to defaults.
// A result waits in the output register under m_tready stall; the next item is
// still accepted and held in its final stage until the output register frees.
`include "mouse_look_vector_rotator_top_defines.svh"

module mouse_look_vector_rotator_top #(
    parameter int  COORD_BITS     = mlvr_pkg::COORD_BITS_DEF,
    parameter int  ROTATION_STEPS = mlvr_pkg::ROTATION_STEPS_DEF,
    localparam int S_DATA_BITS    =
        ((2 * COORD_BITS + mlvr_pkg::NUM_VECS * mlvr_pkg::VEC_BITS + 7) / 8) * 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // pointer_x, pointer_y, view_dir_x, view_dir_y, view_plane_x, view_plane_y
    input  logic [S_DATA_BITS-1:0]                s_tdata,
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // rotated_dir_x, rotated_dir_y, rotated_plane_x, rotated_plane_y,
    // cursor_action, warp_x, warp_y
    output logic [mlvr_pkg::M_DATA_BITS-1:0]      m_tdata,
    // configuration writes
    input  logic                                  cfg_wr_en,
    input  logic [mlvr_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [mlvr_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data
);

    localparam int VB        = mlvr_pkg::VEC_BITS;
    localparam int WB        = mlvr_pkg::W_BITS;
    localparam int ZB        = mlvr_pkg::Z_BITS;
    localparam int CB        = mlvr_pkg::CENTER_BITS;
    localparam int NV        = mlvr_pkg::NUM_VECS;
    localparam int PROD_W    = WB + mlvr_pkg::GAIN_BITS;
    localparam int SH_W      = PROD_W - mlvr_pkg::OUT_SHIFT;
    localparam int ITER_BITS = $clog2(ROTATION_STEPS);
    localparam int GCNT_BITS = $clog2(NV + 1);
    localparam int DIFF_BITS = ((COORD_BITS > CB) ? COORD_BITS : CB) + 2;
    localparam int PAD_BITS  = mlvr_pkg::M_DATA_BITS - NV * VB - mlvr_pkg::ACT_BITS - 2 * CB;

    // top-level sequencer
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ANGLE = 3'd1;
    localparam logic [2:0] ST_FOLD  = 3'd2;
    localparam logic [2:0] ST_ROT   = 3'd3;
    localparam logic [2:0] ST_GAIN  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    // config registers
    logic                            enabled_reg;
    logic [mlvr_pkg::SENS_BITS-1:0]  sens_reg;
    logic [mlvr_pkg::WIN_BITS-1:0]   win_w_reg;
    logic [mlvr_pkg::WIN_BITS-1:0]   win_h_reg;

    // block state
    logic signed [COORD_BITS-1:0]    prev_x_reg;
    logic                            first_move_reg;

    logic [2:0]                      state_reg;
    logic [ITER_BITS-1:0]            iter_reg;
    logic [GCNT_BITS-1:0]            gcnt_reg;

    logic signed [WB-1:0]            w_reg   [NV];
    logic signed [VB-1:0]            res_reg [NV];
    logic signed [ZB-1:0]            z_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic [mlvr_pkg::ACT_BITS-1:0]   act_reg;
    logic [CB-1:0]                   wx_reg;
    logic [CB-1:0]                   wy_reg;

    logic                            m_tvalid_reg;
    logic [mlvr_pkg::M_DATA_BITS-1:0] m_data_reg;

    // input unpack
    logic signed [COORD_BITS-1:0]    px;
    logic signed [COORD_BITS-1:0]    py;
    logic signed [VB-1:0]            vec_in [NV];
    logic                            accept;

    // accept-time decisions
    logic signed [COORD_BITS:0]      delta;
    logic [COORD_BITS:0]             delta_abs;
    logic                            rot_go;
    logic [CB-1:0]                   cx;
    logic [CB-1:0]                   cy;
    logic [COORD_BITS+CB-1:0]        cx_ext;
    logic signed [DIFF_BITS-1:0]     dx;
    logic signed [DIFF_BITS-1:0]     dy;
    logic                            recenter;

    // rotation datapath
    logic signed [WB-1:0]            xs0, ys0, xs1, ys1;
    logic signed [ZB-1:0]            atan_val;
    logic signed [PROD_W-1:0]        prod_next;
    logic signed [PROD_W-1:0]        rnd;
    logic signed [SH_W-1:0]          shifted;
    logic signed [VB-1:0]            sat_val;

    mlvr_pkg::angle_req_t            ang_req;
    logic                            ang_done;
    logic signed [ZB-1:0]            ang_val;

    assign accept = s_tvalid && s_tready;
    assign px     = s_tdata[COORD_BITS-1:0];
    assign py     = s_tdata[2*COORD_BITS-1:COORD_BITS];

    for (genvar k = 0; k < NV; k++) begin : g_unpack
        assign vec_in[k] = s_tdata[2*COORD_BITS + k*VB +: VB];
    end

    always_comb begin
        delta     = {prev_x_reg[COORD_BITS-1], prev_x_reg} - {px[COORD_BITS-1], px};
        delta_abs = delta[COORD_BITS] ? -delta : delta;
        // a zero product leaves the vectors untouched
        rot_go    = enabled_reg && !first_move_reg && (delta != '0) && (sens_reg != '0);

        cx     = win_w_reg[mlvr_pkg::WIN_BITS-1:1];
        cy     = win_h_reg[mlvr_pkg::WIN_BITS-1:1];
        cx_ext = {{COORD_BITS{1'b0}}, cx};
        dx = DIFF_BITS'(px) - $signed({{(DIFF_BITS-CB){1'b0}}, cx});
        dy = DIFF_BITS'(py) - $signed({{(DIFF_BITS-CB){1'b0}}, cy});
        recenter = (dx > DIFF_BITS'(mlvr_pkg::RECENTER_LIMIT))
                || (dx < -DIFF_BITS'(mlvr_pkg::RECENTER_LIMIT))
                || (dy > DIFF_BITS'(mlvr_pkg::RECENTER_LIMIT))
                || (dy < -DIFF_BITS'(mlvr_pkg::RECENTER_LIMIT));

        ang_req.start    = accept && rot_go;
        ang_req.negative = delta[COORD_BITS];
    end

    mlvr_angle #(
        .COORD_BITS (COORD_BITS)
    ) u_angle (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req         (ang_req),
        .delta_mag   (delta_abs[COORD_BITS-1:0]),
        .sensitivity (sens_reg),
        .done        (ang_done),
        .angle       (ang_val)
    );

    // CORDIC step and gain stage
    always_comb begin
        xs0      = w_reg[0] >>> iter_reg;
        ys0      = w_reg[1] >>> iter_reg;
        xs1      = w_reg[2] >>> iter_reg;
        ys1      = w_reg[3] >>> iter_reg;
        atan_val = mlvr_pkg::atan_q30(mlvr_pkg::ATAN_IDX_BITS'(iter_reg));

        prod_next = w_reg[0] * mlvr_pkg::GAIN_INV_Q30;
        rnd       = prod_reg + (PROD_W'(1) << (mlvr_pkg::OUT_SHIFT - 1));
        shifted   = SH_W'(rnd >>> mlvr_pkg::OUT_SHIFT);
        if (shifted > SH_W'(32767)) begin
            sat_val = 16'sh7fff;
        end else if (shifted < -SH_W'(32768)) begin
            sat_val = -16'sh8000;
        end else begin
            sat_val = shifted[VB-1:0];
        end
    end

    // config and block state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg    <= mlvr_pkg::ENABLE_RST;
            sens_reg       <= mlvr_pkg::SENS_RST;
            win_w_reg      <= mlvr_pkg::WIN_W_RST;
            win_h_reg      <= mlvr_pkg::WIN_H_RST;
            prev_x_reg     <= '0;
            first_move_reg <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    mlvr_pkg::REG_ENABLE:      enabled_reg <= cfg_wr_data[0];
                    mlvr_pkg::REG_SENSITIVITY: sens_reg    <= cfg_wr_data;
                    mlvr_pkg::REG_WIN_WIDTH:
                        win_w_reg <= cfg_wr_data[mlvr_pkg::WIN_BITS-1:0];
                    mlvr_pkg::REG_WIN_HEIGHT:
                        win_h_reg <= cfg_wr_data[mlvr_pkg::WIN_BITS-1:0];
                endcase
            end
            // disabled: state untouched
            if (accept && enabled_reg) begin
                first_move_reg <= 1'b0;
                // recenter pins the reference to the center, wrapped to coord width
                prev_x_reg <= recenter ? $signed(cx_ext[COORD_BITS-1:0]) : px;
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            iter_reg     <= '0;
            gcnt_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= rot_go ? ST_ANGLE : ST_FIN;
                    end
                end
                ST_ANGLE: begin
                    if (ang_done) begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    iter_reg  <= '0;
                    state_reg <= ST_ROT;
                end
                ST_ROT: begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_BITS'(ROTATION_STEPS - 1)) begin
                        gcnt_reg  <= '0;
                        state_reg <= ST_GAIN;
                    end
                end
                ST_GAIN: begin
                    gcnt_reg <= gcnt_reg + 1'b1;
                    if (gcnt_reg == GCNT_BITS'(NV)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    for (int k = 0; k < NV; k++) begin
                        res_reg[k] <= vec_in[k];
                        w_reg[k]   <= {{(WB-VB-mlvr_pkg::GUARD_BITS){vec_in[k][VB-1]}},
                                       vec_in[k], {mlvr_pkg::GUARD_BITS{1'b0}}};
                    end
                    if (recenter) begin
                        act_reg <= enabled_reg ? mlvr_pkg::ACT_WARP : mlvr_pkg::ACT_SHOW;
                    end else begin
                        act_reg <= mlvr_pkg::ACT_NONE;
                    end
                    wx_reg <= (recenter && enabled_reg) ? cx : '0;
                    wy_reg <= (recenter && enabled_reg) ? cy : '0;
                end
            end
            ST_ANGLE: begin
                if (ang_done) begin
                    z_reg <= ang_val;
                end
            end
            ST_FOLD: begin
                // beyond +-pi/2: rotate by pi first (negate), shrink angle
                if (z_reg > mlvr_pkg::HALF_PI_Q30) begin
                    for (int k = 0; k < NV; k++) w_reg[k] <= -w_reg[k];
                    z_reg <= z_reg - mlvr_pkg::PI_Q30;
                end else if (z_reg < -mlvr_pkg::HALF_PI_Q30) begin
                    for (int k = 0; k < NV; k++) w_reg[k] <= -w_reg[k];
                    z_reg <= z_reg + mlvr_pkg::PI_Q30;
                end
            end
            ST_ROT: begin
                if (!z_reg[ZB-1]) begin
                    w_reg[0] <= w_reg[0] - ys0;
                    w_reg[1] <= w_reg[1] + xs0;
                    w_reg[2] <= w_reg[2] - ys1;
                    w_reg[3] <= w_reg[3] + xs1;
                    z_reg    <= z_reg - atan_val;
                end else begin
                    w_reg[0] <= w_reg[0] + ys0;
                    w_reg[1] <= w_reg[1] - xs0;
                    w_reg[2] <= w_reg[2] + ys1;
                    w_reg[3] <= w_reg[3] - xs1;
                    z_reg    <= z_reg + atan_val;
                end
            end
            ST_GAIN: begin
                // one shared multiplier: w rotates past it, results shift in
                if (gcnt_reg != GCNT_BITS'(NV)) begin
                    prod_reg <= prod_next;
                    w_reg[0] <= w_reg[1];
                    w_reg[1] <= w_reg[2];
                    w_reg[2] <= w_reg[3];
                    w_reg[3] <= w_reg[0];
                end
                if (gcnt_reg != '0) begin
                    res_reg[0] <= res_reg[1];
                    res_reg[1] <= res_reg[2];
                    res_reg[2] <= res_reg[3];
                    res_reg[3] <= sat_val;
                end
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_data_reg <= {{PAD_BITS{1'b0}}, wy_reg, wx_reg, act_reg,
                                   res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    // warp coordinates only travel with a warp action
    `MLVR_ASSERT_NOW(a_warp_zero, m_tvalid_reg && (m_data_reg[NV*VB+1:NV*VB] != mlvr_pkg::ACT_WARP), m_data_reg[NV*VB+2+2*CB-1:NV*VB+2] == '0, "warp set without warp action")

    // one item at a time
    `MLVR_ASSERT_NEXT(a_busy_after_accept, accept, !s_tready, "input ready right after accept")

    // angle unit only finishes while the sequencer waits for it
    `MLVR_ASSERT_NOW(a_done_in_wait, ang_done, state_reg == ST_ANGLE, "angle done outside wait")

    // iteration count stays inside the CORDIC table
    `MLVR_ASSERT_NOW(a_iter_range, state_reg == ST_ROT, iter_reg <= ITER_BITS'(ROTATION_STEPS - 1), "CORDIC step overrun")

endmodule
